// File: rtl/sbq_pkg.sv
package sbq_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int HIST_W   = 40;
    localparam int ROW_W    = 4 * HIST_W;
    localparam int MOP_W    = 21;
    localparam int CBUS_W   = COEF_W + 1;
    localparam int PROD_W   = CBUS_W + MOP_W;
    localparam int ACC_W    = 76;
    localparam int RAMP_W   = 13;
    localparam int BAND_W   = 4;
    localparam int NCOEF    = 5;
    localparam int DIV_W    = COEF_W + 1;

    localparam logic [COEF_W-1:0] ONE_Q28    = 32'h1000_0000;
    localparam logic [RAMP_W-1:0] RAMP_RESET = 13'd480;

    typedef enum logic [1:0] {
        CMD_SAMPLE    = 2'd0,
        CMD_LOAD_COEF = 2'd1,
        CMD_LOAD_GAIN = 2'd2,
        CMD_COMMIT    = 2'd3
    } sbq_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PASS,
        ST_RRD,
        ST_RSUB,
        ST_RDIV,
        ST_START,
        ST_GLO,
        ST_GHI,
        ST_GACC,
        ST_GEND,
        ST_RD,
        ST_LO,
        ST_HI,
        ST_ACC,
        ST_BEND,
        ST_FIN,
        ST_OUT
    } sbq_state_t;

    typedef struct packed {
        logic              start;
        logic              rd;
        logic              mul_lo;
        logic              mul_hi;
        logic              add_hi;
        logic              gain_end;
        logic              band_end;
        logic              finish;
        logic              mute;
        logic              clear_all;
        logic [2:0]        k;
        logic [BAND_W-1:0] band;
    } sbq_lane_ctl_t;

endpackage

// File: rtl/sbq_if.sv
interface sbq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [23:0] left_in;
    logic [23:0] right_in;
    logic        left_bad;
    logic        right_bad;
    logic [2:0]  band_index;
    logic [2:0]  coef_select;
    logic [31:0] load_value;
    logic        bypass_on;

    modport source (output valid, cmd, left_in, right_in, left_bad, right_bad, band_index,
                    coef_select, load_value, bypass_on, input ready);
    modport sink (input valid, cmd, left_in, right_in, left_bad, right_bad, band_index,
                  coef_select, load_value, bypass_on, output ready);
endinterface

interface sbq_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_out;
    logic [31:0] right_out;
    logic        left_cleared;
    logic        right_cleared;

    modport source (output valid, left_out, right_out, left_cleared, right_cleared,
                    input ready);
    modport sink (input valid, left_out, right_out, left_cleared, right_cleared,
                  output ready);
endinterface

// File: rtl/stereo_biquad_cascade_ramped_unit.sv
// latency: sample 5 + 17 * NUM_BANDS + 3 cycles (144 at eight bands), loads and commit 1 cycle
// during a ramp a sample costs (5 * NUM_BANDS + 1) * 36 more cycles, set by the bit-serial divider
// filter time is set by one 21 x 33 multiplier per lane, two passes per coefficient
// one item in flight; the next item is taken while a result waits in the output register
// async active-low reset: identity coefficients, zero gain, no ramp, history clear, length 480
module stereo_biquad_cascade_ramped_unit #(
    parameter int NUM_BANDS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sbq_in_if.sink                        in_ch,
    sbq_out_if.source                     out_ch,
    input  logic                          wr_en,
    input  logic [sbq_pkg::RAMP_W-1:0]    wr_data
);
    import sbq_pkg::*;

    localparam int NC = NUM_BANDS * NCOEF;
    localparam int AW = $clog2(NC);
    localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

    sbq_state_t state_reg, state_next;

    logic [RAMP_W-1:0]  ramp_len_reg, ramp_len_next;
    logic [RAMP_W-1:0]  ramp_left_reg, ramp_left_next;
    logic               bypass_reg, bypass_next;
    logic [COEF_W-1:0]  gain_reg, gain_next;
    logic [COEF_W-1:0]  level_reg, level_next;
    logic [NC-1:0]      tvld_reg, tvld_next;
    logic [NC-1:0]      cvld_reg, cvld_next;
    logic [BW-1:0]      b_reg, b_next;
    logic [2:0]         k_reg, k_next;
    logic               gstep_reg, gstep_next;
    logic               pass_reg, pass_next;
    logic               out_vld_reg, out_vld_next;
    logic [COEF_W-1:0]  lo_reg, ro_reg;
    logic               lc_reg, rc_reg;
    logic [SAMPLE_W-1:0] xl_reg, xr_reg;
    logic               bl_reg, br_reg;

    logic [COEF_W-1:0]  cur_mem [NC];
    logic [COEF_W-1:0]  tgt_mem [NC];
    logic [COEF_W-1:0]  cur_q_reg, tgt_q_reg;
    logic               cur_qv_reg, tgt_qv_reg;

    logic               in_fire, out_load;
    logic [AW-1:0]      addr, load_addr;
    logic               load_ok, tgt_we, cur_we, rd_en;
    logic [COEF_W-1:0]  ident, cur_eff, tgt_eff, cur_r, tgt_r;
    logic signed [DIV_W-1:0] diff, quot;
    logic               div_start, div_done;
    logic [COEF_W-1:0]  cur_new;
    logic signed [CBUS_W-1:0] coef_bus;
    sbq_lane_ctl_t      ctl;
    logic signed [COEF_W-1:0] l_y, r_y;
    logic               l_c, r_c;
    logic               b_last;

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_OUT) && (!out_vld_reg || out_ch.ready);

    assign addr      = AW'(32'(b_reg) * NCOEF + 32'(k_reg));
    assign load_addr = AW'(32'(in_ch.band_index) * NCOEF + 32'(in_ch.coef_select));
    assign load_ok   = (32'(in_ch.band_index) < NUM_BANDS) && (in_ch.coef_select < 3'd5);
    assign tgt_we    = in_fire && (sbq_cmd_t'(in_ch.cmd) == CMD_LOAD_COEF) && load_ok;
    assign rd_en     = (state_reg == ST_RRD) || (state_reg == ST_RD);
    assign b_last    = (b_reg == BW'(NUM_BANDS - 1));

    // unwritten entries read as identity
    assign ident   = (k_reg == 3'd0) ? ONE_Q28 : '0;
    assign cur_eff = cur_qv_reg ? cur_q_reg : ident;
    assign tgt_eff = tgt_qv_reg ? tgt_q_reg : ident;
    assign cur_r   = gstep_reg ? gain_reg : cur_eff;
    assign tgt_r   = gstep_reg ? level_reg : tgt_eff;
    assign diff    = $signed(DIV_W'($signed(tgt_r))) - $signed(DIV_W'($signed(cur_r)));
    assign div_start = (state_reg == ST_RSUB);
    assign cur_new = COEF_W'($signed(DIV_W'($signed(cur_r))) + quot);
    assign cur_we  = (state_reg == ST_RDIV) && div_done && !gstep_reg;

    always_comb
    begin
        if ((state_reg == ST_GLO) || (state_reg == ST_GHI))
        begin
            coef_bus = CBUS_W'($signed(gain_reg));
        end
        else if (k_reg >= 3'd3)
        begin
            coef_bus = -CBUS_W'($signed(cur_eff));
        end
        else
        begin
            coef_bus = CBUS_W'($signed(cur_eff));
        end
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
        begin
            tgt_mem[load_addr] <= in_ch.load_value;
        end
        if (rd_en)
        begin
            tgt_q_reg  <= tgt_mem[addr];
            tgt_qv_reg <= tvld_reg[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[addr] <= cur_new;
        end
        if (rd_en)
        begin
            cur_q_reg  <= cur_mem[addr];
            cur_qv_reg <= cvld_reg[addr];
        end
    end

    sbq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff),
        .divisor  (ramp_left_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        ctl       = '0;
        ctl.k     = k_reg;
        ctl.band  = BAND_W'(b_reg);
        unique case (state_reg)
            ST_PASS:  ctl.clear_all = 1'b1;
            ST_START: ctl.start     = 1'b1;
            ST_GLO:   ctl.mul_lo    = 1'b1;
            ST_GHI:   ctl.mul_hi    = 1'b1;
            ST_GACC:  ctl.add_hi    = 1'b1;
            ST_GEND:  ctl.gain_end  = 1'b1;
            ST_RD:
            begin
                ctl.rd     = 1'b1;
                ctl.add_hi = (k_reg != 3'd0);
            end
            ST_LO:    ctl.mul_lo    = 1'b1;
            ST_HI:    ctl.mul_hi    = 1'b1;
            ST_ACC:   ctl.add_hi    = 1'b1;
            ST_BEND:  ctl.band_end  = 1'b1;
            ST_FIN:
            begin
                ctl.finish = 1'b1;
                ctl.mute   = (ramp_left_reg == '0) && (level_reg == '0);
            end
            default:  ctl.k         = k_reg;
        endcase
    end

    sbq_lane #(.NUM_BANDS(NUM_BANDS)) u_lane_l (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .x       (xl_reg),
        .bad     (bl_reg),
        .coef    (coef_bus),
        .y_out   (l_y),
        .cleared (l_c)
    );

    sbq_lane #(.NUM_BANDS(NUM_BANDS)) u_lane_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .x       (xr_reg),
        .bad     (br_reg),
        .coef    (coef_bus),
        .y_out   (r_y),
        .cleared (r_c)
    );

    always_comb
    begin
        state_next     = state_reg;
        ramp_len_next  = wr_en ? wr_data : ramp_len_reg;
        ramp_left_next = ramp_left_reg;
        bypass_next    = bypass_reg;
        gain_next      = gain_reg;
        level_next     = level_reg;
        tvld_next      = tvld_reg;
        cvld_next      = cvld_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        gstep_next     = gstep_reg;
        pass_next      = pass_reg;
        out_vld_next   = out_vld_reg;
        if (out_ch.ready)
        begin
            out_vld_next = 1'b0;
        end
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        if (tgt_we)
        begin
            tvld_next[load_addr] = 1'b1;
        end
        if (cur_we)
        begin
            cvld_next[addr] = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (sbq_cmd_t'(in_ch.cmd))
                        CMD_LOAD_GAIN: level_next = in_ch.load_value;
                        CMD_COMMIT:
                        begin
                            bypass_next = in_ch.bypass_on;
                            if (in_ch.bypass_on)
                            begin
                                tvld_next  = '0;
                                level_next = ONE_Q28;
                            end
                            ramp_left_next = (ramp_len_reg == '0) ? RAMP_W'(1) : ramp_len_reg;
                        end
                        CMD_SAMPLE:
                        begin
                            b_next     = '0;
                            k_next     = '0;
                            gstep_next = 1'b0;
                            pass_next  = (ramp_left_reg == '0) && bypass_reg;
                            if ((ramp_left_reg == '0) && bypass_reg)
                            begin
                                state_next = ST_PASS;
                            end
                            else if (ramp_left_reg != '0)
                            begin
                                state_next = ST_RRD;
                            end
                            else
                            begin
                                state_next = ST_START;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PASS:  state_next = ST_OUT;
            ST_RRD:   state_next = ST_RSUB;
            ST_RSUB:  state_next = ST_RDIV;
            ST_RDIV:
            begin
                if (div_done)
                begin
                    if (gstep_reg)
                    begin
                        gain_next      = cur_new;
                        ramp_left_next = ramp_left_reg - 1'b1;
                        gstep_next     = 1'b0;
                        b_next         = '0;
                        k_next         = '0;
                        state_next     = ST_START;
                    end
                    else
                    begin
                        state_next = ST_RRD;
                        if (k_reg == 3'd4)
                        begin
                            k_next = '0;
                            if (b_last)
                            begin
                                gstep_next = 1'b1;
                            end
                            else
                            begin
                                b_next = b_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                end
            end
            ST_START: state_next = ST_GLO;
            ST_GLO:   state_next = ST_GHI;
            ST_GHI:   state_next = ST_GACC;
            ST_GACC:  state_next = ST_GEND;
            ST_GEND:  state_next = ST_RD;
            ST_RD:    state_next = ST_LO;
            ST_LO:    state_next = ST_HI;
            ST_HI:
            begin
                if (k_reg == 3'd4)
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_ACC:   state_next = ST_BEND;
            ST_BEND:
            begin
                k_next = '0;
                if (b_last)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    b_next     = b_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ramp_len_reg  <= RAMP_RESET;
            ramp_left_reg <= '0;
            bypass_reg    <= 1'b0;
            gain_reg      <= '0;
            level_reg     <= '0;
            tvld_reg      <= '0;
            cvld_reg      <= '0;
            b_reg         <= '0;
            k_reg         <= '0;
            gstep_reg     <= 1'b0;
            pass_reg      <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ramp_len_reg  <= ramp_len_next;
            ramp_left_reg <= ramp_left_next;
            bypass_reg    <= bypass_next;
            gain_reg      <= gain_next;
            level_reg     <= level_next;
            tvld_reg      <= tvld_next;
            cvld_reg      <= cvld_next;
            b_reg         <= b_next;
            k_reg         <= k_next;
            gstep_reg     <= gstep_next;
            pass_reg      <= pass_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    // captured sample beat and the output register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            xl_reg <= in_ch.left_in;
            xr_reg <= in_ch.right_in;
            bl_reg <= in_ch.left_bad;
            br_reg <= in_ch.right_bad;
        end
        if (out_load)
        begin
            if (pass_reg)
            begin
                lo_reg <= bl_reg ? '0 : COEF_W'($signed(xl_reg));
                ro_reg <= br_reg ? '0 : COEF_W'($signed(xr_reg));
                lc_reg <= 1'b1;
                rc_reg <= 1'b1;
            end
            else
            begin
                lo_reg <= l_y;
                ro_reg <= r_y;
                lc_reg <= l_c;
                rc_reg <= r_c;
            end
        end
    end

    assign out_ch.valid         = out_vld_reg;
    assign out_ch.left_out      = lo_reg;
    assign out_ch.right_out     = ro_reg;
    assign out_ch.left_cleared  = lc_reg;
    assign out_ch.right_cleared = rc_reg;

    a_pass_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && pass_reg) |=> (out_ch.left_cleared && out_ch.right_cleared))
        else $error("passthrough result without history clear");

    a_ramp_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RDIV) && div_done && gstep_reg)
        |=> (ramp_left_reg == $past(ramp_left_reg) - 1'b1))
        else $error("ramp counter did not step by one");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_RDIV))
        else $error("divider finished outside ramp update");

endmodule

// File: rtl/sbq_div.sv
module sbq_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [sbq_pkg::DIV_W-1:0]    dividend,
    input  logic        [sbq_pkg::RAMP_W-1:0]   divisor,
    output logic                                done,
    output logic signed [sbq_pkg::DIV_W-1:0]    quotient
);
    import sbq_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0]  mag_reg, mag_next;
    logic [RAMP_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic [RAMP_W:0]   rem_sh;
    logic              ge;

    always_comb
    begin
        rem_sh    = {rem_reg, mag_reg[DIV_W-1]};
        ge        = (rem_sh >= {1'b0, divisor});
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start)
        begin
            mag_next  = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            neg_next  = dividend[DIV_W-1];
        end
        else if (busy_reg)
        begin
            // one quotient bit a cycle, restoring
            rem_next = ge ? RAMP_W'(rem_sh - {1'b0, divisor}) : RAMP_W'(rem_sh);
            mag_next = {mag_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

endmodule

// File: rtl/sbq_lane.sv
module sbq_lane #(
    parameter int NUM_BANDS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sbq_pkg::sbq_lane_ctl_t               ctl,
    input  logic signed [sbq_pkg::SAMPLE_W-1:0]  x,
    input  logic                                 bad,
    input  logic signed [sbq_pkg::CBUS_W-1:0]    coef,
    output logic signed [sbq_pkg::COEF_W-1:0]    y_out,
    output logic                                 cleared
);
    import sbq_pkg::*;

    localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

    logic [ROW_W-1:0]        hist_mem [NUM_BANDS];
    logic [ROW_W-1:0]        row_q_reg;
    logic                    row_vld_q_reg;
    logic [NUM_BANDS-1:0]    hvld_reg, hvld_next;
    logic signed [HIST_W-1:0] value_reg, value_next;
    logic                    skip_reg, skip_next;
    logic                    clr_reg, clr_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] p_reg, p_next;
    logic signed [COEF_W-1:0] yout_reg, yout_next;
    logic                    cout_reg, cout_next;

    logic [ROW_W-1:0]         row_eff;
    logic signed [HIST_W-1:0] h0, h1, h2, opa;
    logic signed [MOP_W-1:0]  mop;
    logic signed [ACC_W-1:0]  rnd_full;
    logic                     ovf40;
    logic signed [HIST_W-1:0] fin_v;
    logic                     ovf32;
    logic                     row_we;
    logic [BW-1:0]            bidx;

    assign bidx    = ctl.band[BW-1:0];
    assign row_eff = row_vld_q_reg ? row_q_reg : '0;
    assign h0      = row_eff[HIST_W-1:0];
    assign h1      = row_eff[2*HIST_W-1:HIST_W];
    assign h2      = row_eff[3*HIST_W-1:2*HIST_W];

    always_comb
    begin
        case (ctl.k)
            3'd0:    opa = value_reg;
            3'd1:    opa = h0;
            3'd2:    opa = h1;
            3'd3:    opa = h2;
            default: opa = row_eff[4*HIST_W-1:3*HIST_W];
        endcase
    end

    // operand split into unsigned low 20 bits and signed high 20 bits
    assign mop = ctl.mul_hi ? {opa[HIST_W-1], opa[HIST_W-1:20]} : {1'b0, opa[19:0]};

    assign rnd_full = (acc_reg + (ACC_W'(1) <<< 27)) >>> 28;
    assign ovf40 = !((&rnd_full[ACC_W-1:HIST_W-1]) || !(|rnd_full[ACC_W-1:HIST_W-1]));
    assign fin_v = ctl.mute ? '0 : value_reg;
    assign ovf32 = !((&fin_v[HIST_W-1:COEF_W-1]) || !(|fin_v[HIST_W-1:COEF_W-1]));
    assign row_we = ctl.band_end && !skip_reg && !ovf40;

    always_comb
    begin
        hvld_next  = hvld_reg;
        value_next = value_reg;
        skip_next  = skip_reg;
        clr_next   = clr_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        yout_next  = yout_reg;
        cout_next  = cout_reg;
        if (ctl.mul_lo || ctl.mul_hi)
        begin
            p_next = coef * mop;
        end
        if (ctl.mul_hi)
        begin
            acc_next = acc_reg + ACC_W'(p_reg);
        end
        if (ctl.add_hi)
        begin
            acc_next = acc_reg + (ACC_W'(p_reg) <<< 20);
        end
        if (ctl.start)
        begin
            acc_next   = '0;
            value_next = bad ? '0 : HIST_W'(x);
            skip_next  = bad;
            clr_next   = bad;
            if (bad)
            begin
                hvld_next = '0;
            end
        end
        if (ctl.gain_end)
        begin
            value_next = rnd_full[HIST_W-1:0];
            acc_next   = '0;
        end
        if (ctl.band_end)
        begin
            acc_next = '0;
            if (!skip_reg)
            begin
                if (ovf40)
                begin
                    // band overflow drops the rest of the cascade
                    hvld_next  = '0;
                    skip_next  = 1'b1;
                    clr_next   = 1'b1;
                    value_next = '0;
                end
                else
                begin
                    hvld_next[bidx] = 1'b1;
                    value_next      = rnd_full[HIST_W-1:0];
                end
            end
        end
        if (ctl.finish)
        begin
            if (ovf32)
            begin
                hvld_next = '0;
                yout_next = '0;
                cout_next = 1'b1;
            end
            else
            begin
                yout_next = fin_v[COEF_W-1:0];
                cout_next = clr_reg;
            end
        end
        if (ctl.clear_all)
        begin
            hvld_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvld_reg <= '0;
            skip_reg <= 1'b0;
            clr_reg  <= 1'b0;
            cout_reg <= 1'b0;
        end
        else
        begin
            hvld_reg <= hvld_next;
            skip_reg <= skip_next;
            clr_reg  <= clr_next;
            cout_reg <= cout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        acc_reg   <= acc_next;
        p_reg     <= p_next;
        yout_reg  <= yout_next;
    end

    // history row: h0, h1 (inputs), h2, h3 (outputs)
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            hist_mem[bidx] <= {h2, rnd_full[HIST_W-1:0], h0, value_reg};
        end
        if (ctl.rd)
        begin
            row_q_reg     <= hist_mem[bidx];
            row_vld_q_reg <= hvld_reg[bidx];
        end
    end

    assign y_out   = yout_reg;
    assign cleared = cout_reg;

endmodule
